@@ rtl/core/rat_pkg.sv @@
// Shared widths, operation codes and state encodings of the rational ALU.
package rat_pkg;

  localparam int OPW = 16;            // operand width
  localparam int PW  = 2 * OPW;       // product width
  localparam int RW  = PW + 1;        // result width
  localparam int UW  = RW - 1;        // magnitude width of a positive result
  localparam int CW  = $clog2(UW);    // shift and bit counter width

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MUL3 = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_RED  = 6'b100000
  } state_e;

  typedef enum logic [5:0] {
    RS_IDLE = 6'b000001,
    RS_TWO  = 6'b000010,
    RS_GCD  = 6'b000100,
    RS_DIVN = 6'b001000,
    RS_DIVD = 6'b010000,
    RS_DONE = 6'b100000
  } red_state_e;

endpackage

@@ rtl/core/rat_red.sv @@
// Reduction unit: binary GCD and two restoring divisions on one shared subtractor.
module rat_red
  import rat_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [UW-1:0] num_i,
  input  logic [UW-1:0] den_i,
  output logic          done_o,
  output logic [UW-1:0] num_o,
  output logic [UW-1:0] den_o
);

  red_state_e    state_q, state_d;
  logic [UW-1:0] x_q, x_d, y_q, y_d, g_q, g_d;
  logic [UW-1:0] rem_q, rem_d, quo_q, quo_d, qn_q, qn_d, dsave_q, dsave_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;

  logic [UW:0]   sub_a, sub_b;
  logic [UW+1:0] sub_diff;
  logic          borrow;

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_diff[UW+1];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    g_d     = g_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    qn_d    = qn_q;
    dsave_d = dsave_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    sub_a   = {1'b0, x_q};
    sub_b   = {1'b0, y_q};
    case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          x_d     = num_i;
          y_d     = den_i;
          quo_d   = num_i;
          dsave_d = den_i;
          k_d     = '0;
          state_d = RS_TWO;
        end
      end
      RS_TWO: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CW'(1);
        end else begin
          state_d = RS_GCD;
        end
      end
      RS_GCD: begin
        if (x_q == '0) begin
          g_d     = y_q << k_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = RS_DIVN;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (borrow) begin
          x_d = y_q;
          y_d = x_q;
        end else begin
          x_d = sub_diff[UW-1:0];
        end
      end
      RS_DIVN, RS_DIVD: begin
        sub_a = {rem_q, quo_q[UW-1]};
        sub_b = {1'b0, g_q};
        rem_d = borrow ? {rem_q[UW-2:0], quo_q[UW-1]} : sub_diff[UW-1:0];
        quo_d = {quo_q[UW-2:0], ~borrow};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(UW - 1)) begin
          cnt_d = '0;
          if (state_q == RS_DIVN) begin
            qn_d    = quo_d;
            quo_d   = dsave_q;
            rem_d   = '0;
            state_d = RS_DIVD;
          end else begin
            state_d = RS_DONE;
          end
        end
      end
      RS_DONE: begin
        state_d = RS_IDLE;
      end
      default: begin
        state_d = RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    g_q     <= g_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    qn_q    <= qn_d;
    dsave_q <= dsave_d;
  end

  assign done_o = (state_q == RS_DONE);
  assign num_o  = qn_q;
  assign den_o  = quo_q;

endmodule

@@ rtl/core/rational_alu_with_reduction.sv @@
// Rational ALU: add, subtract, multiply or divide two fractions; a result positive in both parts is reduced by its GCD.
//
// Command channel: a transfer happens at a rising edge with start_i high and busy_o
// low; cmd_i, a_num_i, a_den_i, b_num_i and b_den_i are sampled there.
// Result channel: done_o is high for exactly one cycle with res_num_o and res_den_o
// valid; the receiver must take them in that cycle, it cannot stall the block.
// One command gives exactly one result.
// Sequence: three products, one by one, on one shared 16x16 multiplier, a step to
// combine the products, then the result strobe. A pair that is not strictly positive
// in both parts leaves straight after the combine step. A positive pair goes through
// the reduction unit: binary GCD on one shared subtractor (common twos stripped one
// per cycle, then one shift, swap or subtract per cycle), then two 32-step restoring
// divisions on the same subtractor.
// busy_o stays high from the transfer until done_o rises; a new command can be
// taken at the edge that closes the strobe cycle.
// Reset (rst_ni low, asynchronous) returns both sequencers to idle and drops
// busy_o and done_o; no command in flight survives it.
module rational_alu_with_reduction
  import rat_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            cmd_i,
  input  logic signed [OPW-1:0] a_num_i,
  input  logic signed [OPW-1:0] a_den_i,
  input  logic signed [OPW-1:0] b_num_i,
  input  logic signed [OPW-1:0] b_den_i,
  output logic                  done_o,
  output logic signed [RW-1:0]  res_num_o,
  output logic signed [RW-1:0]  res_den_o
);

  state_e                state_q, state_d;
  cmd_e                  cmd_q;
  logic signed [OPW-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0]  p1_q, p2_q, p3_q;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [RW-1:0]  sum, den_x;
  logic signed [RW-1:0]  res_num_d, res_den_d;
  logic                  done_d, both_pos;
  logic                  red_start, red_done;
  logic [UW-1:0]         red_num, red_den;

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    case (state_q)
      ST_MUL1: begin
        mul_a = an_q;
        mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
      end
      ST_MUL2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_q)
      CMD_ADD: sum = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
      CMD_SUB: sum = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
      default: sum = {p1_q[PW-1], p1_q};
    endcase
  end

  assign den_x     = {p3_q[PW-1], p3_q};
  assign both_pos  = !sum[RW-1] && (sum != '0) && !den_x[RW-1] && (den_x != '0);
  assign red_start = (state_q == ST_SUM) && both_pos;

  rat_red u_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(red_start),
    .num_i  (sum[UW-1:0]),
    .den_i  (den_x[UW-1:0]),
    .done_o (red_done),
    .num_o  (red_num),
    .den_o  (red_den)
  );

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    res_num_d = res_num_o;
    res_den_d = res_den_o;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_SUM;
      ST_SUM: begin
        if (both_pos) begin
          state_d = ST_RED;
        end else begin
          res_num_d = sum;
          res_den_d = den_x;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_RED: begin
        if (red_done) begin
          res_num_d = {1'b0, red_num};
          res_den_d = {1'b0, red_den};
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cmd_q <= cmd_e'(cmd_i);
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
    end
    if (state_q == ST_MUL1) p1_q <= mul_p;
    if (state_q == ST_MUL2) p2_q <= mul_p;
    if (state_q == ST_MUL3) p3_q <= mul_p;
    res_num_o <= res_num_d;
    res_den_o <= res_den_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  a_accept_no_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("command transfer not followed by busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_reduced_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (red_num != '0 && red_den != '0 && state_q == ST_RED))
    else $error("reduction gave a zero part or finished outside reduction");

endmodule
